### hdl/mlprq_pkg.sv
`timescale 1ns / 1ps
// Shared operation codes and stream field widths for the priority ring queue.
package mlprq_pkg;

  typedef enum logic [2:0] {
    OP_SUBMIT   = 3'd0,
    OP_DISPATCH = 3'd1,
    OP_COMPLETE = 3'd2,
    OP_PAUSE    = 3'd3,
    OP_RESUME   = 3'd4
  } op_e;

  localparam int unsigned OpW     = 3;
  localparam int unsigned TagW    = 16;
  localparam int unsigned PrioW   = 2;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned PendW   = 9;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 32;

  // Bit positions inside the input tdata word.
  localparam int unsigned InOpLo   = 0;
  localparam int unsigned InTagLo  = InOpLo + OpW;
  localparam int unsigned InPrioLo = InTagLo + TagW;
  localparam int unsigned InSizeLo = InPrioLo + PrioW;
  localparam int unsigned InBufBit = InSizeLo + SizeW;

  // Packed from the top down, so accepted lands in bit zero.
  typedef struct packed {
    logic              idle;
    logic [PendW-1:0]  pending_total;
    logic [PrioW-1:0]  dispatched_priority;
    logic [TagW-1:0]   dispatched_tag;
    logic              accepted;
  } result_t;

endpackage

### hdl/multi_level_priority_ring_queue_unit.sv
`timescale 1ns / 1ps
// Strict-priority ring queue: one FIFO ring per level, all rings in one tag memory.
//
// Each item is an operation (submit, dispatch, complete, pause, resume) and yields
// exactly one result item. An item is taken every cycle while the result side keeps
// up: the pointers and counts update at the accepting edge, and a dispatch reads the
// tag memory at that edge, so the result follows in the next cycle from the memory's
// registered read port. The tag memory holds LEVELS*CAPACITY entries, is never
// cleared, and only entries written since reset are ever read.
module multi_level_priority_ring_queue_unit #(
  parameter int unsigned LEVELS   = 4,
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // operation[2:0], request_tag[18:3], priority_req[20:19], request_size[52:21],
  // has_buffers[53], zero[55:54]
  input  logic [mlprq_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // accepted[0], dispatched_tag[16:1], dispatched_priority[18:17],
  // pending_total[27:19], idle[28], zero[31:29]
  output logic [mlprq_pkg::OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned Depth = LEVELS * CAPACITY;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned LvlW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned TotW  = $clog2(Depth + 2);

  // Decoded input fields.
  logic [mlprq_pkg::OpW-1:0]   op;
  logic [mlprq_pkg::TagW-1:0]  in_tag;
  logic [mlprq_pkg::PrioW-1:0] in_prio;
  logic [mlprq_pkg::SizeW-1:0] in_size;
  logic                        in_bufs;

  assign op      = s_axis_tdata[mlprq_pkg::InOpLo +: mlprq_pkg::OpW];
  assign in_tag  = s_axis_tdata[mlprq_pkg::InTagLo +: mlprq_pkg::TagW];
  assign in_prio = s_axis_tdata[mlprq_pkg::InPrioLo +: mlprq_pkg::PrioW];
  assign in_size = s_axis_tdata[mlprq_pkg::InSizeLo +: mlprq_pkg::SizeW];
  assign in_bufs = s_axis_tdata[mlprq_pkg::InBufBit];

  // Ring bookkeeping.
  logic [IdxW-1:0] heads_q [LEVELS];
  logic [IdxW-1:0] heads_d [LEVELS];
  logic [IdxW-1:0] tails_q [LEVELS];
  logic [IdxW-1:0] tails_d [LEVELS];
  logic [CntW-1:0] counts_q [LEVELS];
  logic [CntW-1:0] counts_d [LEVELS];
  logic [TotW-1:0] queued_q, queued_d;
  logic            busy_q, busy_d;
  logic            hold_q, hold_d;

  // Tag memory with a registered read port.
  logic [TAG_BITS-1:0] mem [Depth];
  logic [TAG_BITS-1:0] rd_data_q;
  logic                wr_en, rd_en;
  logic [AddrW-1:0]    wr_addr, rd_addr;

  // Result register.
  logic                        out_valid_q;
  logic                        res_ok_q, res_ok_d;
  logic                        res_disp_q, res_disp_d;
  logic [mlprq_pkg::PrioW-1:0] res_prio_q, res_prio_d;
  logic [TotW-1:0]             res_pend_q, res_pend_d;

  logic            take;
  logic            sub_ok, disp_ok;
  logic            any_queued;
  logic [LvlW-1:0] sel_lvl;
  logic [LvlW-1:0] sub_lvl;
  logic [TotW-1:0] count_sum;
  mlprq_pkg::result_t res;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign sub_lvl       = LvlW'(in_prio);

  // Most urgent non-empty level.
  always_comb begin
    sel_lvl    = '0;
    any_queued = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (counts_q[l] != '0) begin
        sel_lvl    = LvlW'(l);
        any_queued = 1'b1;
      end
    end
  end

  always_comb begin
    count_sum = '0;
    for (int l = 0; l < LEVELS; l++) begin
      count_sum = count_sum + TotW'(counts_q[l]);
    end
  end

  always_comb begin
    heads_d    = heads_q;
    tails_d    = tails_q;
    counts_d   = counts_q;
    queued_d   = queued_q;
    busy_d     = busy_q;
    hold_d     = hold_q;
    sub_ok     = 1'b0;
    disp_ok    = 1'b0;
    res_disp_d = 1'b0;
    res_prio_d = '0;
    unique case (op)
      mlprq_pkg::OP_SUBMIT: begin
        if (in_tag != '0 && in_size != '0 && in_bufs &&
            32'(in_prio) < LEVELS && counts_q[sub_lvl] < CntW'(CAPACITY)) begin
          sub_ok            = 1'b1;
          heads_d[sub_lvl]  = (heads_q[sub_lvl] == IdxW'(CAPACITY - 1)) ? '0
                                                                         : heads_q[sub_lvl] + 1'b1;
          counts_d[sub_lvl] = counts_q[sub_lvl] + 1'b1;
          queued_d          = queued_q + 1'b1;
        end
      end
      mlprq_pkg::OP_DISPATCH: begin
        res_disp_d = 1'b1;
        if (!hold_q && !busy_q && any_queued) begin
          disp_ok           = 1'b1;
          res_prio_d        = mlprq_pkg::PrioW'(sel_lvl);
          tails_d[sel_lvl]  = (tails_q[sel_lvl] == IdxW'(CAPACITY - 1)) ? '0
                                                                         : tails_q[sel_lvl] + 1'b1;
          counts_d[sel_lvl] = counts_q[sel_lvl] - 1'b1;
          queued_d          = queued_q - 1'b1;
          busy_d            = 1'b1;
        end
      end
      mlprq_pkg::OP_COMPLETE: busy_d = 1'b0;
      mlprq_pkg::OP_PAUSE:    hold_d = 1'b1;
      mlprq_pkg::OP_RESUME:   hold_d = 1'b0;
      default: ;
    endcase
    res_ok_d   = sub_ok || disp_ok;
    res_pend_d = queued_d + TotW'(busy_d);
  end

  assign wr_en   = take && sub_ok;
  assign rd_en   = take && disp_ok;
  assign wr_addr = AddrW'(sub_lvl * CAPACITY + heads_q[sub_lvl]);
  assign rd_addr = AddrW'(sel_lvl * CAPACITY + tails_q[sel_lvl]);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= TAG_BITS'(in_tag);
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        heads_q[l]  <= '0;
        tails_q[l]  <= '0;
        counts_q[l] <= '0;
      end
      queued_q    <= '0;
      busy_q      <= 1'b0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        heads_q  <= heads_d;
        tails_q  <= tails_d;
        counts_q <= counts_d;
        queued_q <= queued_d;
        busy_q   <= busy_d;
        hold_q   <= hold_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_ok_q   <= res_ok_d;
      res_disp_q <= res_disp_d;
      res_prio_q <= res_prio_d;
      res_pend_q <= res_pend_d;
    end
  end

  // The dispatched tag comes straight from the memory's read register.
  always_comb begin
    res.accepted            = res_ok_q;
    res.dispatched_tag      = (res_ok_q && res_disp_q) ? mlprq_pkg::TagW'(rd_data_q) : '0;
    res.dispatched_priority = res_prio_q;
    res.pending_total       = mlprq_pkg::PendW'(res_pend_q);
    res.idle                = (res_pend_q == '0);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = mlprq_pkg::OutDataW'(res);

  // The queued total always agrees with the per-level counts.
  a_total_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queued_q == count_sum)
    else $error("queued total differs from the sum of ring counts");

  // A successful dispatch still waiting on the output means a request is in flight.
  a_dispatch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_ok_q && res_disp_q) |-> busy_q)
    else $error("dispatched item shown without a request in flight");

  // A dispatch is never granted while paused.
  a_no_dispatch_paused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && hold_q) |-> !disp_ok)
    else $error("dispatch granted while paused");

endmodule
